// ===== hdl/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

    // request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // configuration register
    localparam int unsigned CAP_W        = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic REG_CAPACITY = 1'b0;

    // one request
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } request_t;

    // one result
    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic clear_cnt;
        logic decide;
        logic upd_rd;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_last;
        logic need_update;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/lkv_ram.sv =====
`default_nettype none

module lkv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/lkv_ctrl.sv =====
`default_nettype none

module lkv_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lkv_pkg::dp_status_t status,
    output      lkv_pkg::dp_cmd_t  cmd,
    output      logic              busy,
    output      logic              done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_UPDATE,
        S_UPD_END,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide    = 1'b1;
                cmd.clear_cnt = 1'b1;
                state_next    = status.need_update ? S_UPDATE : S_FINISH;
            end
            S_UPDATE:
            begin
                cmd.upd_rd = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_UPD_END;
                end
            end
            S_UPD_END:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
        done_next = (state_next == S_FINISH);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/lkv_datapath.sv =====
`default_nettype none

module lkv_datapath #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lkv_pkg::dp_cmd_t              cmd,
    input  wire lkv_pkg::request_t             request,
    input  wire logic [lkv_pkg::CAP_W-1:0]     capacity,
    output      lkv_pkg::dp_status_t           status,
    output      lkv_pkg::result_t              result
);

    localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned AW   = IW;
    localparam int unsigned OW   = $clog2(ENTRIES + 1);
    localparam int unsigned CMPW = (OW > lkv_pkg::CAP_W) ? OW : lkv_pkg::CAP_W;
    localparam int unsigned WW   = 64 + AW;

    // request and sweep control
    lkv_pkg::request_t req_reg;
    logic [IW-1:0]     cnt_reg;
    logic [IW-1:0]     pipe_idx_reg;
    logic              cmp_v_reg;
    logic              upd_v_reg;

    // entry state kept in flops
    logic [ENTRIES-1:0] valid_reg;
    logic [OW-1:0]      occ_reg;

    // scan findings
    logic          found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [31:0]   hit_data_reg;
    logic [AW-1:0] hit_age_reg;
    logic [IW-1:0] lru_idx_reg;
    logic [31:0]   lru_key_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;

    // update controls
    logic          [IW-1:0] slot_reg;
    logic          [AW-1:0] old_age_reg;
    logic                   all_age_reg;
    logic                   wr_key_reg;
    logic                   wr_data_reg;
    lkv_pkg::result_t       result_reg;

    // memory ports
    logic          ram_we;
    logic [WW-1:0] ram_wdata;
    logic [WW-1:0] ram_rdata;
    logic [31:0]   rd_key;
    logic [31:0]   rd_data;
    logic [AW-1:0] rd_age;

    // lookup helpers
    logic            rd_valid;
    logic            key_match;
    logic [OW-1:0]   occ_m1;
    logic            is_lru;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] cap_eff;
    logic            full;
    logic            is_slot;
    logic            ages;
    logic [AW-1:0]   new_age;
    logic            is_put;
    logic            claim_free;
    logic            evict_now;

    lkv_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pipe_idx_reg),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[WW-1 -: 32];
    assign rd_data = ram_rdata[AW+31 -: 32];
    assign rd_age  = ram_rdata[AW-1:0];

    // compare stage on the word just read
    assign rd_valid  = valid_reg[pipe_idx_reg];
    assign key_match = rd_valid && (rd_key == req_reg.lookup_key);
    assign occ_m1    = occ_reg - 1'b1;
    assign is_lru    = rd_valid && (rd_age == occ_m1[AW-1:0]);

    // effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        cap_ext = CMPW'(capacity);
        if (capacity == '0)
        begin
            cap_eff = CMPW'(1);
        end
        else if (cap_ext > CMPW'(ENTRIES))
        begin
            cap_eff = CMPW'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign full = CMPW'(occ_reg) >= cap_eff;

    // outcome of a put on a new key
    assign is_put     = (req_reg.req_type == lkv_pkg::REQ_PUT);
    assign claim_free = !found_reg && is_put && !full;
    assign evict_now  = !found_reg && is_put && full;

    // write-back stage of the recency update
    assign is_slot = (pipe_idx_reg == slot_reg);
    assign ages    = rd_valid && (all_age_reg || (rd_age < old_age_reg));

    always_comb
    begin
        if (is_slot)
        begin
            new_age = '0;
        end
        else if (ages)
        begin
            new_age = rd_age + 1'b1;
        end
        else
        begin
            new_age = rd_age;
        end
        ram_wdata = {(is_slot && wr_key_reg)  ? req_reg.lookup_key  : rd_key,
                     (is_slot && wr_data_reg) ? req_reg.write_value : rd_data,
                     new_age};
    end

    assign ram_we = upd_v_reg;

    // status to the controller
    assign status.cnt_last    = (cnt_reg == IW'(ENTRIES - 1));
    assign status.need_update = found_reg || is_put;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            cmp_v_reg      <= 1'b0;
            upd_v_reg      <= 1'b0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= cmd.scan_rd;
            upd_v_reg <= cmd.upd_rd;
            if (cmd.accept || cmd.clear_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_rd || cmd.upd_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmp_v_reg)
            begin
                if (key_match)
                begin
                    found_reg <= 1'b1;
                end
                if (!rd_valid)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            // a new key without eviction claims the free entry
            if (cmd.decide && claim_free)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                occ_reg                 <= occ_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= cnt_reg;
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        // first match, least recent entry, first free entry
        if (cmp_v_reg)
        begin
            if (key_match && !found_reg)
            begin
                hit_idx_reg  <= pipe_idx_reg;
                hit_data_reg <= rd_data;
                hit_age_reg  <= rd_age;
            end
            if (is_lru)
            begin
                lru_idx_reg <= pipe_idx_reg;
                lru_key_reg <= rd_key;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_idx_reg <= pipe_idx_reg;
            end
        end
        // settle the outcome of the request
        if (cmd.decide)
        begin
            result_reg.hit         <= found_reg;
            result_reg.read_value  <= (found_reg && !is_put) ? hit_data_reg : '0;
            result_reg.evicted     <= evict_now;
            result_reg.evicted_key <= evict_now ? lru_key_reg : '0;
            if (found_reg)
            begin
                slot_reg    <= hit_idx_reg;
                old_age_reg <= hit_age_reg;
                all_age_reg <= 1'b0;
                wr_key_reg  <= 1'b0;
                wr_data_reg <= is_put;
            end
            else
            begin
                old_age_reg <= '0;
                all_age_reg <= 1'b1;
                wr_key_reg  <= 1'b1;
                wr_data_reg <= 1'b1;
                if (full)
                begin
                    slot_reg <= lru_idx_reg;
                end
                else
                begin
                    slot_reg <= free_idx_reg;
                end
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Requests: drive request (get or put, key, value) with start high; the
// request is taken at a rising edge where start is high and busy is low.
// Results: done is high for exactly one cycle with result valid (hit, read
// value, eviction flag and evicted key); the receiver cannot stall it.
// Sweeps: the key memory is swept one entry per cycle, once to find the
// key, the least recent entry and the first free entry, and, for a hit or a
// put, once more to rewrite the recency ages; a get miss has one sweep only.
// busy falls at the edge where the result is taken; no new request is
// accepted before then. The key/data/age memory has a single read port,
// which sets the pace of the sweeps.
// Configuration: capacity_in_use is written over the APB port at address 0.
// The user must write it only while busy is low; the block itself does not
// enforce this. Reset empties the cache (all entries invalid, occupancy
// zero) and sets capacity_in_use to 16; no clearing pass is made.
module lru_key_value_cache #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire lkv_pkg::request_t  request,
    output      logic               done,
    output      lkv_pkg::result_t   result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output      logic [31:0]        prdata,
    output      logic               pready
);

    logic [lkv_pkg::CAP_W-1:0] cap_reg;
    lkv_pkg::dp_cmd_t          cmd;
    lkv_pkg::dp_status_t       status;
    logic                      cfg_wr;
    logic                      cfg_sel;

    // register decode
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == lkv_pkg::REG_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? {{(32 - lkv_pkg::CAP_W){1'b0}}, cap_reg} : 32'd0;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkv_pkg::CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    lkv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lkv_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .capacity (cap_reg),
        .status   (status),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== test/lru_key_value_cache_tb.sv =====
`default_nettype none

module lru_key_value_cache_tb;

    localparam int NUM_SLOTS   = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 2 * NUM_SLOTS + 8;

    // register map: capacity at index 0, index 1 holds nothing
    localparam logic [2:0] CAP_ADDR   = {lkv_pkg::REG_CAPACITY, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    // recency limit that makes every other valid entry older
    localparam logic [4:0] AGE_ALL = 5'd31;

    localparam logic [31:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_ZERO = 32'h0000_0000;
    localparam logic [31:0] KEY_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} op_kind_t;

    typedef enum logic [2:0] {
        DRV_IDLE, DRV_GAP, DRV_REQ, DRV_QUIET, DRV_SETUP, DRV_ACCESS, DRV_END
    } drv_state_t;

    typedef struct {
        op_kind_t           kind;
        lkv_pkg::request_t  req;
        int                 gap;
        logic [2:0]         addr;
        logic [31:0]        data;
    } pending_op_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // block inputs, known from time zero
    logic              start       = 1'b0;
    lkv_pkg::request_t request_drv = '0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;

    logic             busy;
    logic             done;
    lkv_pkg::result_t result;
    logic [31:0]      prdata;
    logic             pready;

    lru_key_value_cache #(.ENTRIES(NUM_SLOTS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request_drv),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the cache contents
    logic signed [31:0]        line_key   [NUM_SLOTS];
    logic signed [31:0]        line_data  [NUM_SLOTS];
    logic                      line_valid [NUM_SLOTS];
    logic [3:0]                line_age   [NUM_SLOTS];
    logic [4:0]                occupancy      = '0;
    logic [lkv_pkg::CAP_W-1:0] cache_capacity = lkv_pkg::CAP_RESET;

    pending_op_t      stim_q[$];
    lkv_pkg::result_t awaited_results[$];
    pending_op_t      cur_op;
    drv_state_t       drv_state  = DRV_IDLE;
    int               gap_left   = 0;
    bit               stim_done  = 1'b0;
    logic [31:0]      key_pool[32];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int get_count      = 0;
    int put_count      = 0;
    int hit_count      = 0;
    int evict_count    = 0;
    int cfg_count      = 0;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            line_valid[i] = 1'b0;
            line_age[i]   = '0;
        end
    end

    // mark one entry most recent, aging the entries newer than old_age
    function automatic void promote_entry(int slot, logic [4:0] old_age);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (line_valid[i] && i != slot && {1'b0, line_age[i]} < old_age)
                line_age[i] = line_age[i] + 4'd1;
        end
        line_age[slot] = '0;
    endfunction

    // lookup or insert against the shadow cache, returning the expected result
    function automatic lkv_pkg::result_t predict_lookup(lkv_pkg::request_t rq);
        lkv_pkg::result_t r;
        int               found_slot;
        int               pick;
        bit               claimed;
        logic [4:0]       cap_eff;
        r          = '0;
        found_slot = -1;
        pick       = 0;
        claimed    = 1'b0;
        if (rq.req_type == lkv_pkg::REQ_PUT)
            put_count++;
        else
            get_count++;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (found_slot < 0 && line_valid[i] && line_key[i] == rq.lookup_key)
                found_slot = i;
        end
        if (found_slot >= 0)
        begin
            r.hit = 1'b1;
            hit_count++;
            if (rq.req_type == lkv_pkg::REQ_PUT)
                line_data[found_slot] = rq.write_value;
            else
                r.read_value = line_data[found_slot];
            promote_entry(found_slot, {1'b0, line_age[found_slot]});
        end
        else if (rq.req_type == lkv_pkg::REQ_PUT)
        begin
            // zero acts as one, anything above the entry count as the full cache
            if (cache_capacity == 0)
                cap_eff = 5'd1;
            else if (cache_capacity > NUM_SLOTS)
                cap_eff = 5'(NUM_SLOTS);
            else
                cap_eff = cache_capacity;
            // full: reuse the least recent entry
            if (occupancy >= cap_eff)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (line_valid[i] && (!claimed || line_age[i] > line_age[pick]))
                    begin
                        pick    = i;
                        claimed = 1'b1;
                    end
                end
                if (claimed)
                begin
                    r.evicted     = 1'b1;
                    r.evicted_key = line_key[pick];
                    evict_count++;
                    promote_entry(pick, AGE_ALL);
                end
            end
            // otherwise the lowest free entry
            if (!claimed)
            begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                begin
                    if (!line_valid[i])
                    begin
                        pick    = i;
                        claimed = 1'b1;
                    end
                end
                if (claimed)
                begin
                    line_valid[pick] = 1'b1;
                    occupancy        = occupancy + 5'd1;
                    promote_entry(pick, AGE_ALL);
                end
            end
            if (claimed)
            begin
                line_key[pick]  = rq.lookup_key;
                line_data[pick] = rq.write_value;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // pick up the next pending operation, keeping start high for a back-to-back request
    task automatic advance_stream;
        if (stim_q.size() == 0)
        begin
            start     <= 1'b0;
            stim_done = 1'b1;
            drv_state <= DRV_END;
        end
        else
        begin
            cur_op   = stim_q.pop_front();
            gap_left = cur_op.gap;
            if (cur_op.kind == OP_REQ && cur_op.gap == 0)
            begin
                request_drv <= cur_op.req;
                start       <= 1'b1;
                drv_state   <= DRV_REQ;
            end
            else
            begin
                start     <= 1'b0;
                drv_state <= DRV_GAP;
            end
        end
    endtask

    // driver: requests on start/busy, register writes over apb while idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state <= DRV_IDLE;
        end
        else
        begin
            case (drv_state)
                DRV_IDLE:
                    advance_stream();
                DRV_GAP:
                begin
                    if (gap_left > 1)
                        gap_left = gap_left - 1;
                    else if (cur_op.kind == OP_REQ)
                    begin
                        request_drv <= cur_op.req;
                        start       <= 1'b1;
                        drv_state   <= DRV_REQ;
                    end
                    else
                        drv_state <= DRV_QUIET;
                end
                DRV_REQ:
                begin
                    if (!busy)
                    begin
                        awaited_results.push_back(predict_lookup(request_drv));
                        advance_stream();
                    end
                end
                DRV_QUIET:
                begin
                    // hold off until every outstanding result is back
                    if (awaited_results.size() == 0 && !busy)
                    begin
                        if (cur_op.kind == OP_DRAIN)
                            advance_stream();
                        else
                        begin
                            psel      <= 1'b1;
                            penable   <= 1'b0;
                            pwrite    <= 1'b1;
                            paddr     <= cur_op.addr;
                            pwdata    <= cur_op.data;
                            drv_state <= DRV_SETUP;
                        end
                    end
                end
                DRV_SETUP:
                begin
                    penable   <= 1'b1;
                    drv_state <= DRV_ACCESS;
                end
                DRV_ACCESS:
                begin
                    if (pready)
                    begin
                        if (paddr == CAP_ADDR)
                            cache_capacity = pwdata[lkv_pkg::CAP_W-1:0];
                        cfg_count++;
                        psel    <= 1'b0;
                        penable <= 1'b0;
                        pwrite  <= 1'b0;
                        advance_stream();
                    end
                end
                default:
                    start <= 1'b0;
            endcase
        end
    end

    // monitor: compare each result strobe with the oldest expectation
    lkv_pkg::result_t want;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result strobe with no request outstanding");
            else
            begin
                want = awaited_results.pop_front();
                if (result.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", result.hit, want.hit));
                if (result.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              result.read_value, want.read_value));
                if (result.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %b, expected %b",
                                              result.evicted, want.evicted));
                if (result.evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key %h, expected %h",
                                              result.evicted_key, want.evicted_key));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_gap(bit idle_on);
        return idle_on ? int'($urandom_range(0, 17)) : 0;
    endfunction

    task automatic add_request(input logic kind, input logic [31:0] key,
                               input logic [31:0] val, input bit idle_on);
        pending_op_t op;
        op.kind             = OP_REQ;
        op.req.req_type     = kind;
        op.req.lookup_key   = key;
        op.req.write_value  = val;
        op.gap              = draw_gap(idle_on);
        op.addr             = '0;
        op.data             = '0;
        stim_q.push_back(op);
    endtask

    task automatic add_cfg(input logic [2:0] addr, input logic [31:0] data);
        pending_op_t op;
        op.kind = OP_CFG;
        op.req  = '0;
        op.gap  = 0;
        op.addr = addr;
        op.data = data;
        stim_q.push_back(op);
    endtask

    // stimulus and end of run
    initial begin
        int          pool_size;
        int          cap_sel;
        bit          idle_on;
        logic [31:0] key;
        pending_op_t drain_op;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = KEY_ZERO;
        key_pool[3] = KEY_ONES;
        for (int i = 4; i < 32; i++)
            key_pool[i] = $urandom();

        // directed: extreme keys and values, update, miss on empty cache
        add_request(lkv_pkg::REQ_GET, KEY_ZERO, $urandom(), 1'b1);
        add_request(lkv_pkg::REQ_PUT, KEY_MIN, KEY_MAX, 1'b1);
        add_request(lkv_pkg::REQ_PUT, KEY_MAX, KEY_MIN, 1'b1);
        add_request(lkv_pkg::REQ_PUT, KEY_ZERO, KEY_ZERO, 1'b0);
        add_request(lkv_pkg::REQ_PUT, KEY_ONES, KEY_ONES, 1'b0);
        add_request(lkv_pkg::REQ_GET, KEY_MIN, $urandom(), 1'b1);
        add_request(lkv_pkg::REQ_GET, KEY_MAX, $urandom(), 1'b0);
        add_request(lkv_pkg::REQ_GET, 32'h1234_5678, $urandom(), 1'b1);
        add_request(lkv_pkg::REQ_PUT, KEY_ZERO, 32'hA5A5_5A5A, 1'b1);
        add_request(lkv_pkg::REQ_GET, KEY_ZERO, $urandom(), 1'b0);
        // capacity dropped below occupancy: one eviction per new key
        add_cfg(CAP_ADDR, 32'd2);
        add_request(lkv_pkg::REQ_PUT, 32'h0000_0100, $urandom(), 1'b1);
        add_request(lkv_pkg::REQ_PUT, 32'h0000_0200, $urandom(), 1'b0);
        add_request(lkv_pkg::REQ_GET, KEY_ZERO, $urandom(), 1'b1);
        add_request(lkv_pkg::REQ_GET, KEY_ONES, $urandom(), 1'b1);
        // zero capacity behaves as one
        add_cfg(CAP_ADDR, 32'd0);
        add_request(lkv_pkg::REQ_PUT, 32'h0000_0300, $urandom(), 1'b1);
        add_request(lkv_pkg::REQ_PUT, 32'h0000_0400, $urandom(), 1'b0);
        add_request(lkv_pkg::REQ_GET, 32'h0000_0400, $urandom(), 1'b1);
        // write to an unused index is ignored, then oversize capacity
        add_cfg(SPARE_ADDR, 32'd1);
        add_cfg(CAP_ADDR, 32'd31);
        for (int i = 0; i < 5; i++)
            add_request(lkv_pkg::REQ_PUT, 32'h0000_0500 + i, $urandom(), 1'b1);
        add_request(lkv_pkg::REQ_GET, 32'h0000_0100, $urandom(), 1'b0);
        add_request(lkv_pkg::REQ_GET, 32'h0000_0502, $urandom(), 1'b1);

        // random phases, each under its own capacity
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
                cap_sel = 16;
            else if (ph == 1)
                cap_sel = 1;
            else
                cap_sel = $urandom_range(0, 31);
            add_cfg(CAP_ADDR, {27'($urandom() >> 5), 5'(cap_sel)});
            pool_size = $urandom_range(2, 28);
            idle_on   = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 56; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    key = $urandom();
                add_request(logic'($urandom_range(0, 1)), key, $urandom(), idle_on);
                // one pause mid-run until the cache has answered everything
                if (ph == 3 && n == 28)
                begin
                    drain_op      = stim_q[stim_q.size() - 1];
                    drain_op.kind = OP_DRAIN;
                    drain_op.gap  = 0;
                    stim_q.push_back(drain_op);
                end
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(stim_done && awaited_results.size() == 0))
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d gets and %0d puts: %0d hits, %0d evictions",
                 get_count, put_count, hit_count, evict_count);
        $display("%0d register writes, capacities from zero to oversize, %0d mismatches",
                 cfg_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
